[sv/lrl_pkg.sv]
// Shared types and constants for the LRU recency list unit.
package lrl_pkg;

  localparam int KEY_W  = 32;
  localparam int CFG_W  = 4;
  localparam int HPOS_W = 3;

  // Active capacity after reset.
  localparam logic [CFG_W-1:0] CAP_RESET = 4'd8;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_UPD  = 3'b100
  } lrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_key;
    logic compare;
    logic update;
  } lrl_cmd_t;

endpackage

[sv/lru_recency_list_unit.sv]
// Top level of the LRU recency list unit.
//
//   Channel   Handshake               Payload
//   input     start / busy            in_key
//   result    out_valid (strobe)      out_hit, out_hit_position, out_evicted, out_evicted_key
//   config    cfg_valid / cfg_ready   cfg_data (active capacity)
//
// A request passes through a compare stage and then an update stage, and a new request
// can be taken during update; busy is high only during compare.
// The result strobe is registered from the update stage and lasts one cycle.
// The receiver cannot stall; the result registers are reloaded by the next update.
// rst_n is synchronous: the list empties and active capacity returns to 8.
module lru_recency_list_unit
  import lrl_pkg::*;
#(
  parameter int CAPACITY = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [KEY_W-1:0] in_key,
  output logic                    out_valid,
  output logic                    out_hit,
  output logic       [HPOS_W-1:0] out_hit_position,
  output logic                    out_evicted,
  output logic signed [KEY_W-1:0] out_evicted_key,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic        [CFG_W-1:0] cfg_data
);

  lrl_cmd_t cmd;

  // The capacity register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  lrl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  lrl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_key           (in_key),
    .cfg_valid        (cfg_valid && cfg_ready),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_hit_position (out_hit_position),
    .out_evicted      (out_evicted),
    .out_evicted_key  (out_evicted_key)
  );

endmodule

[sv/lrl_ctrl.sv]
// Controller state machine for the LRU recency list unit.
module lrl_ctrl
  import lrl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output lrl_cmd_t cmd
);

  lrl_state_t state_r, state_nxt;
  logic       accept;

  // A request is taken whenever the compare stage is free.
  assign busy   = (state_r == ST_CMP);
  assign accept = start && !busy;

  // Next state: compare, then update; a new request may enter during update.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_CMP;
      end
      ST_CMP: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        state_nxt = accept ? ST_CMP : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Commands to the datapath.
  always_comb begin
    cmd.load_key = accept;
    cmd.compare  = (state_r == ST_CMP);
    cmd.update   = (state_r == ST_UPD);
  end

endmodule

[sv/lrl_datapath.sv]
// Datapath of the LRU recency list unit: key list, compare and shift logic.
module lrl_datapath
  import lrl_pkg::*;
#(
  parameter int CAPACITY = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lrl_cmd_t                cmd,
  input  logic signed [KEY_W-1:0] in_key,
  input  logic                    cfg_valid,
  input  logic        [CFG_W-1:0] cfg_data,
  output logic                    out_valid,
  output logic                    out_hit,
  output logic       [HPOS_W-1:0] out_hit_position,
  output logic                    out_evicted,
  output logic signed [KEY_W-1:0] out_evicted_key
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int NW = (CW > CFG_W) ? CW : CFG_W;

  logic [KEY_W-1:0] entries_r [CAPACITY];
  logic [KEY_W-1:0] key_r;
  logic [CFG_W-1:0] cap_r;
  logic [CW-1:0]    fill_r;
  logic [CAPACITY-1:0] match_r;
  logic             full_r;
  logic [IW-1:0]    last_r;

  logic [NW-1:0]    cap_ext;
  logic [CW-1:0]    cap_eff;
  logic [CW-1:0]    cap_m1;
  logic [CW-1:0]    fill_clamp;
  logic             full_c;
  logic [IW-1:0]    last_c;
  logic [CAPACITY-1:0] match_c;

  logic             hit;
  logic [CAPACITY-1:0] first;
  logic [CAPACITY-1:0] therm;
  logic [IW-1:0]    pos;
  logic [IW+2:0]    pos_ext;

  logic             out_valid_r;
  logic             out_hit_r;
  logic [HPOS_W-1:0] out_hpos_r;
  logic             out_evicted_r;
  logic [KEY_W-1:0] out_evkey_r;

  // Effective capacity: zero acts as one, values above CAPACITY saturate.
  always_comb begin
    cap_ext = NW'(cap_r);
    if (cap_ext == '0) cap_ext = NW'(1);
    if (cap_ext > NW'(CAPACITY)) cap_ext = NW'(CAPACITY);
    cap_eff    = cap_ext[CW-1:0];
    cap_m1     = cap_eff - CW'(1);
    fill_clamp = (fill_r > cap_eff) ? cap_eff : fill_r;
    full_c     = (fill_clamp >= cap_eff);
    last_c     = full_c ? cap_m1[IW-1:0] : fill_clamp[IW-1:0];
  end

  // Parallel compare of the key against every valid rank.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_c[i] = (CW'(i) < fill_clamp) && (entries_r[i] == key_r);
    end
  end

  // Lowest matching rank, and the ranks that shift down by one.
  always_comb begin
    hit   = |match_r;
    first = match_r & (~match_r + {{(CAPACITY-1){1'b0}}, 1'b1});
    for (int i = 0; i < CAPACITY; i++) begin
      therm[i] = (IW'(i) <= last_r);
    end
    if (hit) therm = first | (first - {{(CAPACITY-1){1'b0}}, 1'b1});
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) pos = pos | IW'(i);
    end
    pos_ext = {3'b000, pos};
  end

  // Configuration register and control-side registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) cap_r <= cfg_data;
      if (cmd.compare) fill_r <= fill_clamp;
      if (cmd.update && !hit && !full_r) fill_r <= fill_r + CW'(1);
      out_valid_r <= cmd.update;
    end
  end

  // Key capture, compare results and the result registers.
  always_ff @(posedge clk) begin
    if (cmd.load_key) key_r <= $unsigned(in_key);
    if (cmd.compare) begin
      match_r <= match_c;
      full_r  <= full_c;
      last_r  <= last_c;
    end
    if (cmd.update) begin
      out_hit_r     <= hit;
      out_hpos_r    <= hit ? pos_ext[HPOS_W-1:0] : '0;
      out_evicted_r <= !hit && full_r;
      out_evkey_r   <= (!hit && full_r) ? entries_r[last_r] : '0;
    end
  end

  // Recency list: ranks up to the moved or last rank shift down, key enters at front.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      entries_r[0] <= key_r;
      for (int i = 1; i < CAPACITY; i++) begin
        if (therm[i]) entries_r[i] <= entries_r[i-1];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_hit_position = out_hpos_r;
  assign out_evicted      = out_evicted_r;
  assign out_evicted_key  = $signed(out_evkey_r);

endmodule

[sv/lrl_checker.sv]
// Port-level checks for the LRU recency list unit, bound to the top level.
module lrl_checker
  import lrl_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic                    out_valid,
  input logic                    out_hit,
  input logic       [HPOS_W-1:0] out_hit_position,
  input logic                    out_evicted,
  input logic signed [KEY_W-1:0] out_evicted_key
);

  // An accepted request makes the block busy for exactly one cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_busy_one: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held longer than the compare cycle");

  // The strobe is registered from the update stage, which follows the compare stage of
  // the accepted request; the check samples it at the edge that takes the result.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##3 out_valid)
    else $error("result strobe missing after request");

  // A hit never evicts, and a miss reports rank zero.
  a_hit_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_evicted) && (out_hit || out_hit_position == '0))
    else $error("inconsistent hit and eviction report");

  // Without an eviction the evicted key reads zero.
  a_evkey_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted |-> out_evicted_key == '0)
    else $error("evicted key nonzero without eviction");

endmodule

bind lru_recency_list_unit lrl_checker u_chk (.*);

[bench/lru_recency_list_unit_test.sv]
// Self-checking testbench for the LRU recency list unit, with its own recency predictor.
`timescale 1ns / 1ps

module lru_recency_list_unit_test;
  import lrl_pkg::*;

  localparam int LIST_DEPTH   = 8;
  localparam int CFG_INDEX    = 0;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REPORT_MAX   = 10;

  // One predicted response of the list to an access request.
  typedef struct {
    logic              hit;
    logic [HPOS_W-1:0] hit_position;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
  } access_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic signed [KEY_W-1:0] in_key = '0;
  logic                    out_valid;
  logic                    out_hit;
  logic       [HPOS_W-1:0] out_hit_position;
  logic                    out_evicted;
  logic signed [KEY_W-1:0] out_evicted_key;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic        [CFG_W-1:0] cfg_data = '0;

  // Predictor state: keys by recency rank, number held, capacity register.
  logic [KEY_W-1:0] model_order [LIST_DEPTH];
  int               model_fill = 0;
  logic [CFG_W-1:0] model_capacity = CAP_RESET;

  access_result_t access_results_due[$];
  int             mismatch_count = 0;
  int             cycle_count = 0;
  bit             gaps_enabled = 1'b1;
  bit             gap_stretch = 1'b0;

  lru_recency_list_unit #(
    .CAPACITY(LIST_DEPTH)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_key(in_key),
    .out_valid(out_valid),
    .out_hit(out_hit),
    .out_hit_position(out_hit_position),
    .out_evicted(out_evicted),
    .out_evicted_key(out_evicted_key),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               access_results_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endfunction

  // Predict the response to one access and advance the predicted list.
  function automatic access_result_t predict_access(input logic [KEY_W-1:0] key);
    int             limit;
    int             rank;
    int             last;
    bit             found;
    access_result_t res;
    limit = int'(model_capacity);
    if (limit < 1) limit = 1;
    if (limit > LIST_DEPTH) limit = LIST_DEPTH;
    // A lowered capacity drops the oldest keys silently.
    if (model_fill > limit) model_fill = limit;
    found = 1'b0;
    rank = 0;
    for (int i = 0; i < model_fill; i++) begin
      if (!found && model_order[i] == key) begin
        found = 1'b1;
        rank = i;
      end
    end
    res.hit = found;
    res.hit_position = found ? rank[HPOS_W-1:0] : '0;
    res.evicted = 1'b0;
    res.evicted_key = '0;
    if (found) begin
      last = rank;
    end else if (model_fill >= limit) begin
      last = limit - 1;
      res.evicted = 1'b1;
      res.evicted_key = model_order[last];
    end else begin
      last = model_fill;
      model_fill++;
    end
    for (int i = last; i > 0; i--) begin
      model_order[i] = model_order[i-1];
    end
    model_order[0] = key;
    return res;
  endfunction

  // Compare every result strobe with the oldest outstanding prediction.
  always @(posedge clk) begin
    access_result_t due;
    if (rst_n && out_valid) begin
      if (access_results_due.size() == 0) begin
        note_mismatch($sformatf("unexpected result: hit=%0b pos=%0d evicted=%0b key=%h",
                                out_hit, out_hit_position, out_evicted, out_evicted_key));
      end else begin
        due = access_results_due.pop_front();
        if (out_hit !== due.hit || out_hit_position !== due.hit_position ||
            out_evicted !== due.evicted || out_evicted_key !== due.evicted_key) begin
          note_mismatch($sformatf(
            "mismatch: expected hit=%0b pos=%0d evicted=%0b key=%h, got %0b %0d %0b %h",
            due.hit, due.hit_position, due.evicted, due.evicted_key,
            out_hit, out_hit_position, out_evicted, out_evicted_key));
        end
      end
    end
  end

  // Present one access request and hold it until the unit takes it.
  task automatic send_key(input logic [KEY_W-1:0] key);
    start <= 1'b1;
    in_key <= key;
    do @(posedge clk); while (busy);
    access_results_due.push_back(predict_access(key));
  endtask

  // Between requests, idle for a random burst while gaps are on.
  task automatic maybe_idle();
    if ($urandom_range(0, 39) == 0) gap_stretch = ~gap_stretch;
    if (gaps_enabled && gap_stretch && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Lower start and wait until every predicted result has been checked.
  task automatic wait_drained();
    start <= 1'b0;
    while (access_results_due.size() != 0) @(posedge clk);
  endtask

  // Write the capacity register; the unit must be idle.
  task automatic write_capacity(input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_capacity = value;
  endtask

  // Draw a key: mostly from a small working set, sometimes anything at all.
  function automatic logic [KEY_W-1:0] pick_key(input logic [KEY_W-1:0] pool[$]);
    if ($urandom_range(0, 3) != 0) begin
      return pool[$urandom_range(0, pool.size() - 1)];
    end
    return $urandom;
  endfunction

  task automatic apply_reset();
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  // Fill the list with extreme keys, then hit the front, the back and the middle.
  task automatic test_fill_and_hits();
    logic [KEY_W-1:0] fill_keys[8] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                                       32'hFFFF_FFFF, 32'h0000_0001, 32'hAAAA_AAAA,
                                       32'h5555_5555, 32'hFFFF_FFFE};
    write_capacity(4'd8);
    foreach (fill_keys[i]) send_key(fill_keys[i]);
    send_key(32'hFFFF_FFFE);
    send_key(32'h8000_0000);
    send_key(32'h0000_0001);
    send_key(32'h1234_5678);
    wait_drained();
  endtask

  // Lower the capacity under a full list: old keys vanish without eviction.
  task automatic test_capacity_lowered();
    write_capacity(4'd3);
    send_key(32'hAAAA_AAAA);
    send_key(32'h1234_5678);
    wait_drained();
  endtask

  // Out-of-range capacities: zero acts as one, values above the depth clamp.
  task automatic test_capacity_bounds();
    write_capacity(4'd0);
    send_key(32'h0BAD_F00D);
    send_key(32'h0BAD_F00D);
    send_key(32'hDEAD_BEEF);
    wait_drained();
    write_capacity(4'd15);
    send_key(32'hC0DE_0001);
    send_key(32'hC0DE_0002);
    send_key(32'hDEAD_BEEF);
    wait_drained();
  endtask

  // Random accesses over many capacity settings, gapless at the end.
  task automatic test_random_traffic();
    logic [CFG_W-1:0] settings[7] = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd2, 4'd7, 4'd4};
    logic [KEY_W-1:0] pool[$];
    logic [CFG_W-1:0] setting;
    int               phases;
    phases = 16;
    for (int p = 0; p < phases; p++) begin
      setting = (p < 7) ? settings[p] : CFG_W'($urandom_range(0, 15));
      wait_drained();
      write_capacity(setting);
      pool.delete();
      repeat ((setting == 0 ? 1 : (int'(setting) > LIST_DEPTH ? LIST_DEPTH : int'(setting))) +
              int'($urandom_range(0, 4))) begin
        pool.push_back($urandom);
      end
      gaps_enabled = (p < phases - 2);
      for (int n = 0; n < 88; n++) begin
        maybe_idle();
        send_key(pick_key(pool));
        // Hold off once until the unit has answered everything.
        if (p == 4 && n == 40) wait_drained();
      end
    end
  endtask

  initial begin
    foreach (model_order[i]) model_order[i] = '0;
    apply_reset();
    test_fill_and_hits();
    test_capacity_lowered();
    test_capacity_bounds();
    test_random_traffic();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && access_results_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
